// ===== hw/rtl/dsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrf_pkg
// Shared types and constants for the dictionary substring row filter.
// ----------------------------------------------------------------------------
package dsrf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_NEEDLE_BYTES_DEF   = 16;
  localparam int DICTIONARY_ENTRIES_DEF = 4096;

  // Fixed field widths
  localparam int NEEDLE_W    = 128;  // two 64-bit needle registers
  localparam int NEEDLE_LEN_W = 5;
  localparam int ENTRY_W     = 12;
  localparam int COUNT_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_EMPTY = 2'd1,
    ACT_ROW   = 2'd2,
    ACT_START = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEEDLE_LOW  = 2'd0,
    REG_NEEDLE_HIGH = 2'd1,
    REG_NEEDLE_LEN  = 2'd2
  } cfg_reg_t;

  // Request kinds carried from front to back
  typedef enum logic [1:0] {
    OP_VERDICT,
    OP_ROW,
    OP_CLEAR
  } op_t;

  // One queued request: verdict flag, mask bit for a row, or a clear
  typedef struct packed {
    op_t                op;
    logic [ENTRY_W-1:0] index;
    logic               flag;
  } req_t;

  // Needle configuration as seen by the front
  typedef struct packed {
    logic [NEEDLE_W-1:0]     needle;
    logic [NEEDLE_LEN_W-1:0] length;
  } needle_cfg_t;

endpackage

// ===== hw/rtl/dictionary_substring_row_filter_core.sv =====
// ----------------------------------------------------------------------------
// dictionary_substring_row_filter_core
// Substring filter over dictionary strings with a verdict bitmap, then
// row-code lookup with a saturating match count.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  config   | cfg_write            | cfg_index, cfg_data
//  input    | in_valid / in_ready  | action, text_byte, last_of_string, row_code
//  output   | out_valid / out_ready| result_kind, entry_index, matched,
//           |                      | match_count
//
//  One request per cycle sustained unless the output stalls; the front compares
//  the full needle window in parallel against each byte in the cycle it is
//  accepted. An accepted request passes the front request register (with the
//  bitmap read), then the queue, then the result register that drives out_valid.
//  rst is synchronous; the bitmap is not cleared and needs no sweep.
//  A stalled output fills the four-entry queue before in_ready drops.
// ----------------------------------------------------------------------------
module dictionary_substring_row_filter_core import dsrf_pkg::*; #(
  parameter int MAX_NEEDLE_BYTES   = MAX_NEEDLE_BYTES_DEF,
  parameter int DICTIONARY_ENTRIES = DICTIONARY_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [7:0]             text_byte,
  input  logic                   last_of_string,
  input  logic [ENTRY_W-1:0]     row_code,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   result_kind,
  output logic [ENTRY_W-1:0]     entry_index,
  output logic                   matched,
  output logic [COUNT_W-1:0]     match_count
);

  logic [CFG_DATA_W-1:0]   needle_bytes_low;
  logic [CFG_DATA_W-1:0]   needle_bytes_high;
  logic [NEEDLE_LEN_W-1:0] needle_length;
  needle_cfg_t             cfg;
  logic                    push;
  req_t                    push_req;
  logic                    q_full;
  logic                    pop;
  logic                    q_valid;
  req_t                    head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_bytes_low  <= '0;
      needle_bytes_high <= '0;
      needle_length     <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_NEEDLE_LOW:  needle_bytes_low  <= cfg_data;
        REG_NEEDLE_HIGH: needle_bytes_high <= cfg_data;
        REG_NEEDLE_LEN:  needle_length     <= cfg_data[NEEDLE_LEN_W-1:0];
        default: begin
          // unused index
        end
      endcase
    end
  end

  assign cfg.needle = {needle_bytes_high, needle_bytes_low};
  assign cfg.length = needle_length;

  dsrf_front #(
    .MAX_NEEDLE_BYTES   (MAX_NEEDLE_BYTES),
    .DICTIONARY_ENTRIES (DICTIONARY_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .text_byte      (text_byte),
    .last_of_string (last_of_string),
    .row_code       (row_code),
    .push           (push),
    .push_req       (push_req),
    .q_full         (q_full)
  );

  dsrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  dsrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .entry_index (entry_index),
    .matched     (matched),
    .match_count (match_count)
  );

endmodule

// ===== hw/rtl/dsrf_ram.sv =====
// ----------------------------------------------------------------------------
// dsrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsrf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read data updates only on a read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/dsrf_front.sv =====
// ----------------------------------------------------------------------------
// dsrf_front
// Accepts input items, runs the byte window compare, keeps the verdict
// bitmap and issues one request per string end, empty string, row or start item.
// ----------------------------------------------------------------------------
module dsrf_front import dsrf_pkg::*; #(
  parameter int MAX_NEEDLE_BYTES   = MAX_NEEDLE_BYTES_DEF,
  parameter int DICTIONARY_ENTRIES = DICTIONARY_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  needle_cfg_t        cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [7:0]         text_byte,
  input  logic               last_of_string,
  input  logic [ENTRY_W-1:0] row_code,
  output logic               push,
  output req_t               push_req,
  input  logic               q_full
);

  localparam int AW = $clog2(DICTIONARY_ENTRIES);
  localparam int SW = $clog2(MAX_NEEDLE_BYTES + 1);
  // One bit above both index widths so the entry count itself fits
  localparam int XW = ((AW > ENTRY_W) ? AW : ENTRY_W) + 1;

  logic [7:0]              window      [MAX_NEEDLE_BYTES];
  logic [7:0]              window_next [MAX_NEEDLE_BYTES];
  logic [NEEDLE_LEN_W-1:0] nidx        [MAX_NEEDLE_BYTES];
  logic [MAX_NEEDLE_BYTES-1:0] pos_ok;
  logic [SW-1:0]           seen;
  logic [SW-1:0]           seen_next;
  logic                    found;
  logic                    hit;
  logic [AW-1:0]           string_number;
  logic [AW-1:0]           string_number_next;
  logic [XW-1:0]           sn_ext;
  logic                    accept;
  action_t                 act;
  logic                    in_range;
  logic                    ram_we;
  logic                    ram_wdata;
  logic                    ram_rdata;

  // Stage after the bitmap read
  logic                    s1_valid;
  op_t                     s1_op;
  logic [ENTRY_W-1:0]      s1_index;
  logic                    s1_flag;

  assign act      = action_t'(action);
  assign push     = s1_valid && !q_full;
  assign in_ready = !s1_valid || !q_full;
  assign accept   = in_valid && in_ready;

  // Window shift with the new byte at position 0
  always_comb begin
    window_next[0] = text_byte;
    for (int i = 1; i < MAX_NEEDLE_BYTES; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign seen_next = (seen < SW'(MAX_NEEDLE_BYTES)) ? seen + 1'b1 : seen;

  // Parallel compare: window position j holds needle byte length-1-j
  always_comb begin
    for (int j = 0; j < MAX_NEEDLE_BYTES; j++) begin
      nidx[j]   = cfg.length - NEEDLE_LEN_W'(j + 1);
      pos_ok[j] = (NEEDLE_LEN_W'(j) >= cfg.length) ||
                  (window_next[j] == cfg.needle[8*nidx[j][3:0] +: 8]);
    end
  end

  assign hit = (cfg.length == '0) ||
               ((cfg.length <= NEEDLE_LEN_W'(MAX_NEEDLE_BYTES)) &&
                (NEEDLE_LEN_W'(seen_next) >= cfg.length) && (&pos_ok));

  // String numbering wraps at the bitmap depth
  assign string_number_next = (string_number == AW'(DICTIONARY_ENTRIES - 1)) ?
                              '0 : string_number + 1'b1;
  assign sn_ext   = XW'(string_number);
  assign in_range = XW'(row_code) < XW'(DICTIONARY_ENTRIES);

  // Bitmap write at string end
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    if (accept) begin
      case (act)
        ACT_BYTE: begin
          ram_we    = last_of_string;
          ram_wdata = found || hit;
        end
        ACT_EMPTY: begin
          ram_we    = 1'b1;
          ram_wdata = (cfg.length == '0);
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  dsrf_ram #(
    .WIDTH (1),
    .DEPTH (DICTIONARY_ENTRIES)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (string_number),
    .wdata (ram_wdata),
    .re    (accept && (act == ACT_ROW)),
    .raddr (AW'(row_code)),
    .rdata (ram_rdata)
  );

  // String state and request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      seen          <= '0;
      found         <= 1'b0;
      string_number <= '0;
    end else begin
      if (push) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        case (act)
          ACT_BYTE: begin
            window <= window_next;
            if (last_of_string) begin
              seen          <= '0;
              found         <= 1'b0;
              string_number <= string_number_next;
              s1_valid      <= 1'b1;
              s1_op         <= OP_VERDICT;
              s1_index      <= sn_ext[ENTRY_W-1:0];
              s1_flag       <= found || hit;
            end else begin
              seen  <= seen_next;
              found <= found || hit;
            end
          end
          ACT_EMPTY: begin
            seen          <= '0;
            found         <= 1'b0;
            string_number <= string_number_next;
            s1_valid      <= 1'b1;
            s1_op         <= OP_VERDICT;
            s1_index      <= sn_ext[ENTRY_W-1:0];
            s1_flag       <= (cfg.length == '0);
          end
          ACT_ROW: begin
            s1_valid <= 1'b1;
            s1_op    <= OP_ROW;
            s1_index <= row_code;
            s1_flag  <= in_range;
          end
          default: begin
            // start of a new query
            seen          <= '0;
            found         <= 1'b0;
            string_number <= '0;
            s1_valid      <= 1'b1;
            s1_op         <= OP_CLEAR;
            s1_index      <= '0;
            s1_flag       <= 1'b0;
          end
        endcase
      end
    end
  end

  // Row mask bit comes from the registered bitmap read
  always_comb begin
    push_req.op    = s1_op;
    push_req.index = s1_index;
    push_req.flag  = (s1_op == OP_ROW) ? (s1_flag && ram_rdata) : s1_flag;
  end

  // A stalled request keeps its contents
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !push) |=> (s1_valid && $stable(s1_op) && $stable(s1_index)))
    else $error("front request changed while stalled");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= SW'(MAX_NEEDLE_BYTES))
    else $error("byte count beyond window depth");

  a_sn_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(string_number) < XW'(DICTIONARY_ENTRIES))
    else $error("string number outside bitmap");

endmodule

// ===== hw/rtl/dsrf_queue.sv =====
// ----------------------------------------------------------------------------
// dsrf_queue
// Small FIFO of requests between the front and the back.
// ----------------------------------------------------------------------------
module dsrf_queue import dsrf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output req_t head
);

  localparam int PW = $clog2(DEPTH);

  req_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full    = (count == (PW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  // Pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_req;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dsrf_back.sv =====
// ----------------------------------------------------------------------------
// dsrf_back
// Executes queued requests: keeps the saturating row match count and
// drives the registered result port.
// ----------------------------------------------------------------------------
module dsrf_back import dsrf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  req_t               head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic [ENTRY_W-1:0] entry_index,
  output logic               matched,
  output logic [COUNT_W-1:0] match_count
);

  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] total_next;
  logic               can_load;

  assign can_load = !out_valid || out_ready;
  assign pop      = q_valid && ((head.op == OP_CLEAR) || can_load);

  // Saturating count of matching rows
  always_comb begin
    case (head.op)
      OP_ROW:   total_next = (head.flag && (total != '1)) ? total + 1'b1 : total;
      OP_CLEAR: total_next = '0;
      default:  total_next = total;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        total <= total_next;
        case (head.op)
          OP_VERDICT: begin
            out_valid   <= 1'b1;
            result_kind <= 1'b0;
            entry_index <= head.index;
            matched     <= head.flag;
            match_count <= '0;
          end
          OP_ROW: begin
            out_valid   <= 1'b1;
            result_kind <= 1'b1;
            entry_index <= head.index;
            matched     <= head.flag;
            match_count <= total_next;
          end
          default: begin
            // clear only touches the count
          end
        endcase
      end
    end
  end

  a_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!(pop && head.op == OP_CLEAR)) |=> (total >= $past(total)))
    else $error("row count dropped without a clear");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    ((total == '1) && !(pop && head.op == OP_CLEAR)) |=> (total == '1))
    else $error("row count wrapped");

  a_verdict_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_kind) |-> (match_count == '0))
    else $error("verdict result with nonzero count");

endmodule
